// ----- rtl/core/tlsc_pkg.sv -----
// Shared types and constants for the two-list second-chance replacement core.
package tlsc_pkg;

  localparam int SLOTS  = 64;
  localparam int IDX_W  = 6;
  localparam int LINK_W = 7;
  localparam int CNT_W  = 7;
  localparam int CFG_W  = 7;
  localparam int PROD_W = 14;

  localparam logic [LINK_W-1:0] NONE_IDX = LINK_W'(SLOTS);
  localparam logic [CFG_W-1:0]  PERCENT_RESET = 7'd50;

  localparam logic CFG_PAGE_LIMIT    = 1'b0;
  localparam logic CFG_DIRTY_PERCENT = 1'b1;

  // Bit positions in the per-slot flag nibble.
  localparam int F_LOCKED     = 0;
  localparam int F_WRITEBACK  = 1;
  localparam int F_REFERENCED = 2;
  localparam int F_DIRTY      = 3;

  typedef enum logic [1:0] {
    MB_NONE     = 2'd0,
    MB_ACTIVE   = 2'd1,
    MB_INACTIVE = 2'd2
  } memb_t;

  typedef enum logic [2:0] {
    REQ_INSERT    = 3'd0,
    REQ_REMOVE    = 3'd1,
    REQ_REFERENCE = 3'd2,
    REQ_DIRTY     = 3'd3,
    REQ_CLEAN     = 3'd4,
    REQ_HOLDS     = 3'd5,
    REQ_VICTIM    = 3'd6,
    REQ_UNUSED    = 3'd7
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_LOAD,
    ST_EXEC,
    ST_UNLINK,
    ST_PUSH1,
    ST_PUSH2,
    ST_RESTART,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic rd;
    logic ld;
    logic flags;
    logic ins;
    logic ignore;
    logic skip;
    logic clrref;
    logic victim;
    logic next_phase;
    logic unl;
    logic psh1;
    logic psh2;
    logic restart;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic listed;
    logic cur_none;
    logic held;
    logic refd;
    logic phase;
    logic found;
  } sts_t;

endpackage

// ----- rtl/core/tlsc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tlsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tlsc_ctrl.sv -----
// Sequencer for list updates and the victim walk.
module tlsc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  tlsc_pkg::sts_t sts,
  output tlsc_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);

  tlsc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tlsc_pkg::ST_IDLE: begin
        if (start) state_next = tlsc_pkg::ST_CHECK;
      end
      tlsc_pkg::ST_CHECK: begin
        if (sts.req == tlsc_pkg::REQ_UNUSED) begin
          state_next = tlsc_pkg::ST_DONE;
        end else if (sts.req == tlsc_pkg::REQ_VICTIM && sts.cur_none) begin
          state_next = sts.phase ? tlsc_pkg::ST_DONE : tlsc_pkg::ST_CHECK;
        end else begin
          state_next = tlsc_pkg::ST_READ;
        end
      end
      tlsc_pkg::ST_READ: state_next = tlsc_pkg::ST_LOAD;
      tlsc_pkg::ST_LOAD: state_next = tlsc_pkg::ST_EXEC;
      tlsc_pkg::ST_EXEC: begin
        case (sts.req)
          tlsc_pkg::REQ_INSERT:
            state_next = sts.listed ? tlsc_pkg::ST_DONE : tlsc_pkg::ST_PUSH1;
          tlsc_pkg::REQ_REMOVE:
            state_next = sts.listed ? tlsc_pkg::ST_UNLINK : tlsc_pkg::ST_DONE;
          tlsc_pkg::REQ_VICTIM: begin
            if (sts.held) begin
              state_next = tlsc_pkg::ST_CHECK;
            end else if (sts.refd || sts.phase) begin
              state_next = tlsc_pkg::ST_UNLINK;
            end else begin
              state_next = tlsc_pkg::ST_DONE;
            end
          end
          default: state_next = tlsc_pkg::ST_DONE;
        endcase
      end
      tlsc_pkg::ST_UNLINK: begin
        state_next = (sts.req == tlsc_pkg::REQ_REMOVE) ? tlsc_pkg::ST_DONE
                                                        : tlsc_pkg::ST_PUSH1;
      end
      tlsc_pkg::ST_PUSH1: state_next = tlsc_pkg::ST_PUSH2;
      tlsc_pkg::ST_PUSH2: begin
        // A promotion during the walk restarts it; anything else is finished.
        state_next = (sts.req == tlsc_pkg::REQ_VICTIM && !sts.found)
                     ? tlsc_pkg::ST_RESTART : tlsc_pkg::ST_DONE;
      end
      tlsc_pkg::ST_RESTART: state_next = tlsc_pkg::ST_CHECK;
      tlsc_pkg::ST_DONE:    state_next = tlsc_pkg::ST_IDLE;
      default:              state_next = tlsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != tlsc_pkg::ST_IDLE);
    done = (state == tlsc_pkg::ST_DONE);
    case (state)
      tlsc_pkg::ST_IDLE: cmd.latch = start;
      tlsc_pkg::ST_CHECK: begin
        if (sts.req == tlsc_pkg::REQ_UNUSED) begin
          cmd.ignore = 1'b1;
        end else if (sts.req == tlsc_pkg::REQ_VICTIM && sts.cur_none) begin
          cmd.next_phase = !sts.phase;
        end
      end
      tlsc_pkg::ST_READ: cmd.rd = 1'b1;
      tlsc_pkg::ST_LOAD: cmd.ld = 1'b1;
      tlsc_pkg::ST_EXEC: begin
        case (sts.req)
          tlsc_pkg::REQ_INSERT: begin
            cmd.ignore = sts.listed;
            cmd.ins    = !sts.listed;
          end
          tlsc_pkg::REQ_REMOVE: ;
          tlsc_pkg::REQ_VICTIM: begin
            if (sts.held) begin
              cmd.skip = 1'b1;
            end else if (sts.refd) begin
              cmd.clrref = 1'b1;
            end else begin
              cmd.victim = 1'b1;
            end
          end
          default: cmd.flags = 1'b1;
        endcase
      end
      tlsc_pkg::ST_UNLINK:  cmd.unl     = 1'b1;
      tlsc_pkg::ST_PUSH1:   cmd.psh1    = 1'b1;
      tlsc_pkg::ST_PUSH2:   cmd.psh2    = 1'b1;
      tlsc_pkg::ST_RESTART: cmd.restart = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/tlsc_datapath.sv -----
// List heads, counters, link and flag memories, and result registers.
module tlsc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  tlsc_pkg::cmd_t              cmd,
  output tlsc_pkg::sts_t              sts,
  input  logic [2:0]                  req_type,
  input  logic [tlsc_pkg::IDX_W-1:0]  slot,
  input  logic                        hold_locked,
  input  logic                        hold_writeback,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [tlsc_pkg::CFG_W-1:0]  cfg_data,
  output logic                        status,
  output logic                        victim_found,
  output logic [tlsc_pkg::IDX_W-1:0]  victim_slot,
  output logic [tlsc_pkg::CNT_W-1:0]  dirty_count,
  output logic [tlsc_pkg::CNT_W-1:0]  total_count,
  output logic                        throttle
);

  localparam int LW = tlsc_pkg::LINK_W;
  localparam int IW = tlsc_pkg::IDX_W;
  localparam int CW = tlsc_pkg::CNT_W;
  localparam int MW = 6;

  tlsc_pkg::req_t req_q;
  logic [LW-1:0] sl, nx, pv;
  logic [1:0]    mb;
  logic [3:0]    fl, fl_new;
  logic          hl, hw, phase, found, status_q;
  logic [IW-1:0] vslot;
  logic [LW-1:0] ah, at, ih, it, dh;
  logic [CW-1:0] ac, ic, dt;
  logic [tlsc_pkg::CFG_W-1:0] page_limit, dirty_percent;
  logic [tlsc_pkg::PROD_W-1:0] thr_prod, dirty_x100;
  logic [tlsc_pkg::SLOTS-1:0] nv, pvv, mv;
  logic rv_n, rv_p, rv_m;
  logic push_act, listed;

  logic          n_we, p_we, m_we;
  logic [IW-1:0] n_wa, p_wa, m_wa;
  logic [LW-1:0] n_wd, p_wd, n_rd, p_rd;
  logic [MW-1:0] m_wd, m_rd;

  tlsc_ram #(.WIDTH(LW), .DEPTH(tlsc_pkg::SLOTS)) u_next (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(sl[IW-1:0]), .rdata(n_rd)
  );
  tlsc_ram #(.WIDTH(LW), .DEPTH(tlsc_pkg::SLOTS)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(sl[IW-1:0]), .rdata(p_rd)
  );
  tlsc_ram #(.WIDTH(MW), .DEPTH(tlsc_pkg::SLOTS)) u_flag (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(sl[IW-1:0]), .rdata(m_rd)
  );

  assign listed   = (mb != tlsc_pkg::MB_NONE);
  assign push_act = !(req_q == tlsc_pkg::REQ_VICTIM && found);
  assign dh       = push_act ? ah : ih;

  always_comb begin
    fl_new = fl;
    case (req_q)
      tlsc_pkg::REQ_REFERENCE: fl_new[tlsc_pkg::F_REFERENCED] = 1'b1;
      tlsc_pkg::REQ_DIRTY: begin
        fl_new[tlsc_pkg::F_REFERENCED] = 1'b1;
        fl_new[tlsc_pkg::F_DIRTY]      = 1'b1;
      end
      tlsc_pkg::REQ_CLEAN: fl_new[tlsc_pkg::F_DIRTY] = 1'b0;
      tlsc_pkg::REQ_HOLDS: begin
        fl_new[tlsc_pkg::F_LOCKED]    = hl;
        fl_new[tlsc_pkg::F_WRITEBACK] = hw;
      end
      default: ;
    endcase
  end

  always_comb begin
    n_we = 1'b0; n_wa = sl[IW-1:0]; n_wd = tlsc_pkg::NONE_IDX;
    p_we = 1'b0; p_wa = sl[IW-1:0]; p_wd = tlsc_pkg::NONE_IDX;
    m_we = 1'b0; m_wa = sl[IW-1:0]; m_wd = {mb, fl};
    if (cmd.flags) begin
      m_we = 1'b1;
      m_wd = {mb, fl_new};
    end
    if (cmd.unl) begin
      n_we = !pv[LW-1];
      n_wa = pv[IW-1:0];
      n_wd = nx;
      p_we = !nx[LW-1];
      p_wa = nx[IW-1:0];
      p_wd = pv;
      m_we = 1'b1;
      m_wd = {tlsc_pkg::MB_NONE, fl};
    end
    if (cmd.psh1) begin
      n_we = 1'b1;
      n_wd = dh;
      p_we = 1'b1;
      m_we = 1'b1;
      m_wd = {push_act ? tlsc_pkg::MB_ACTIVE : tlsc_pkg::MB_INACTIVE, fl};
    end
    if (cmd.psh2) begin
      p_we = !dh[LW-1];
      p_wa = dh[IW-1:0];
      p_wd = sl;
    end
  end

  // Entries never written read back as unlinked, off both lists, flags clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      nv  <= '0;
      pvv <= '0;
      mv  <= '0;
    end else begin
      if (n_we) nv[n_wa]  <= 1'b1;
      if (p_we) pvv[p_wa] <= 1'b1;
      if (m_we) mv[m_wa]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rv_n <= nv[sl[IW-1:0]];
      rv_p <= pvv[sl[IW-1:0]];
      rv_m <= mv[sl[IW-1:0]];
    end
    if (cmd.latch) begin
      req_q <= tlsc_pkg::req_t'(req_type);
      hl    <= hold_locked;
      hw    <= hold_writeback;
      sl    <= (tlsc_pkg::req_t'(req_type) == tlsc_pkg::REQ_VICTIM) ? it : {1'b0, slot};
      vslot <= '0;
    end
    if (cmd.ld) begin
      nx <= rv_n ? n_rd : tlsc_pkg::NONE_IDX;
      pv <= rv_p ? p_rd : tlsc_pkg::NONE_IDX;
      mb <= rv_m ? m_rd[MW-1:4] : tlsc_pkg::MB_NONE;
      fl <= rv_m ? m_rd[3:0] : 4'd0;
    end
    if (cmd.flags)      fl <= fl_new;
    if (cmd.skip)       sl <= pv;
    if (cmd.clrref)     fl[tlsc_pkg::F_REFERENCED] <= 1'b0;
    if (cmd.victim)     vslot <= sl[IW-1:0];
    if (cmd.next_phase) sl <= at;
    if (cmd.restart)    sl <= phase ? at : it;
    thr_prod <= tlsc_pkg::PROD_W'(page_limit) * tlsc_pkg::PROD_W'(dirty_percent);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ah <= tlsc_pkg::NONE_IDX;
      at <= tlsc_pkg::NONE_IDX;
      ih <= tlsc_pkg::NONE_IDX;
      it <= tlsc_pkg::NONE_IDX;
      ac <= '0;
      ic <= '0;
      dt <= '0;
      phase    <= 1'b0;
      found    <= 1'b0;
      status_q <= 1'b0;
      page_limit    <= '0;
      dirty_percent <= tlsc_pkg::PERCENT_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tlsc_pkg::CFG_PAGE_LIMIT) begin
          page_limit <= cfg_data;
        end else begin
          dirty_percent <= cfg_data;
        end
      end
      if (cmd.latch) begin
        phase    <= 1'b0;
        found    <= 1'b0;
        status_q <= 1'b0;
      end
      if (cmd.ignore)     status_q <= 1'b1;
      if (cmd.victim)     found <= 1'b1;
      if (cmd.next_phase) phase <= 1'b1;
      if (cmd.ins && fl[tlsc_pkg::F_DIRTY]) dt <= dt + 1'b1;
      if (cmd.flags) begin
        if (req_q == tlsc_pkg::REQ_DIRTY && !fl[tlsc_pkg::F_DIRTY] && listed) begin
          dt <= dt + 1'b1;
        end else if (req_q == tlsc_pkg::REQ_CLEAN && fl[tlsc_pkg::F_DIRTY] && listed &&
                     dt != '0) begin
          dt <= dt - 1'b1;
        end
      end
      if (cmd.unl) begin
        if (mb == tlsc_pkg::MB_ACTIVE) begin
          if (ah == sl) ah <= nx;
          if (at == sl) at <= pv;
          if (ac != '0) ac <= ac - 1'b1;
        end else begin
          if (ih == sl) ih <= nx;
          if (it == sl) it <= pv;
          if (ic != '0) ic <= ic - 1'b1;
        end
        if (req_q == tlsc_pkg::REQ_REMOVE && fl[tlsc_pkg::F_DIRTY] && dt != '0) begin
          dt <= dt - 1'b1;
        end
      end
      if (cmd.psh2) begin
        if (push_act) begin
          ah <= sl;
          if (at[LW-1]) at <= sl;
          ac <= ac + 1'b1;
        end else begin
          ih <= sl;
          if (it[LW-1]) it <= sl;
          ic <= ic + 1'b1;
        end
      end
    end
  end

  // dirty > floor(limit * percent / 100) is the same as limit * percent < 100 * dirty.
  assign dirty_x100 = {1'b0, dt, 6'd0} + {2'd0, dt, 5'd0} + {5'd0, dt, 2'd0};

  assign status       = status_q;
  assign victim_found = found;
  assign victim_slot  = vslot;
  assign dirty_count  = dt;
  assign total_count  = ac + ic;
  assign throttle     = (page_limit != '0) && (thr_prod < dirty_x100);

  assign sts.req      = req_q;
  assign sts.listed   = listed;
  assign sts.cur_none = sl[LW-1];
  assign sts.held     = fl[tlsc_pkg::F_LOCKED] | fl[tlsc_pkg::F_WRITEBACK];
  assign sts.refd     = fl[tlsc_pkg::F_REFERENCED];
  assign sts.phase    = phase;
  assign sts.found    = found;

endmodule

// ----- rtl/core/two_list_second_chance_lru_core.sv -----
// Top level of the two-list second-chance page replacement core.
//
//  channel   | ports                                           | handshake
//  ----------+-------------------------------------------------+-------------------------
//  request   | req_type, slot, hold_locked, hold_writeback     | start high, busy low
//  result    | status, victim_found, victim_slot, dirty_count, | done strobe, one cycle
//            | total_count, throttle                           |
//  config    | cfg_index, cfg_data                             | cfg_we, one cycle
//
// A flag request runs check, read, load, exec, done; an insert adds the push states and a
// remove the unlink state. Victim selection repeats check, read, load and exec per skipped
// held slot, adds unlink, pushes and restart per promoted referenced slot and a check to
// switch to the active list; each step reads an entry of the registered link and flag RAMs.
// busy rises on accept and holds through the done beat; the next beat is taken after it.
// Synchronous reset clears all lists and counters at once; there is no clearing pass.
// The receiver cannot stall; each result beat is shown for exactly one cycle.
module two_list_second_chance_lru_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  req_type,
  input  logic [tlsc_pkg::IDX_W-1:0]  slot,
  input  logic                        hold_locked,
  input  logic                        hold_writeback,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [tlsc_pkg::CFG_W-1:0]  cfg_data,
  output logic                        done,
  output logic                        status,
  output logic                        victim_found,
  output logic [tlsc_pkg::IDX_W-1:0]  victim_slot,
  output logic [tlsc_pkg::CNT_W-1:0]  dirty_count,
  output logic [tlsc_pkg::CNT_W-1:0]  total_count,
  output logic                        throttle
);

  tlsc_pkg::cmd_t cmd;
  tlsc_pkg::sts_t sts;

  tlsc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  tlsc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .req_type(req_type), .slot(slot),
    .hold_locked(hold_locked), .hold_writeback(hold_writeback),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .status(status), .victim_found(victim_found), .victim_slot(victim_slot),
    .dirty_count(dirty_count), .total_count(total_count), .throttle(throttle)
  );

endmodule

// ----- rtl/core/tlsc_checker.sv -----
// Port-level checks for the replacement core, bound to the top level.
module tlsc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        status,
  input logic                        victim_found,
  input logic [tlsc_pkg::CNT_W-1:0]  dirty_count,
  input logic [tlsc_pkg::CNT_W-1:0]  total_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 !busy)
    else $error("done beat outside a busy window");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    done && victim_found |-> !status)
    else $error("victim found with ignored status");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    done |-> (dirty_count <= total_count) && (total_count <= tlsc_pkg::CNT_W'(tlsc_pkg::SLOTS)))
    else $error("dirty or total count out of range");

endmodule

bind two_list_second_chance_lru_core tlsc_checker u_tlsc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .status(status),
  .victim_found(victim_found), .dirty_count(dirty_count), .total_count(total_count)
);

// ----- dv/two_list_second_chance_lru_checker.sv -----
// Checker for the two-list second-chance core: predicts each result beat and compares it.
`timescale 1ns / 100ps
module two_list_second_chance_lru_checker
  import tlsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [2:0]          req_type,
  input  logic [IDX_W-1:0]    slot,
  input  logic                hold_locked,
  input  logic                hold_writeback,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                done,
  input  logic                status,
  input  logic                victim_found,
  input  logic [IDX_W-1:0]    victim_slot,
  input  logic [CNT_W-1:0]    dirty_count,
  input  logic [CNT_W-1:0]    total_count,
  input  logic                throttle,
  output int                  fail_count,
  output int                  pending,
  output int                  beats_seen,
  output int                  victims_seen
);

  typedef struct packed {
    logic             status;
    logic             found;
    logic [IDX_W-1:0] vslot;
    logic [CNT_W-1:0] dirty;
    logic [CNT_W-1:0] total;
    logic             throttle;
  } outcome_t;

  outcome_t          outcome_q[$];
  logic [LINK_W-1:0] nxt[SLOTS];
  logic [LINK_W-1:0] prv[SLOTS];
  memb_t             memb[SLOTS];
  logic [3:0]        flg[SLOTS];
  logic [LINK_W-1:0] a_head, a_tail, i_head, i_tail;
  int                a_cnt, i_cnt, dirty_tot;
  int                limit_reg, percent_reg;

  function automatic void list_push(input int s, input bit act);
    prv[s] = NONE_IDX;
    if (act) begin
      nxt[s] = a_head;
      if (a_head != NONE_IDX) prv[a_head] = LINK_W'(s);
      a_head = LINK_W'(s);
      if (a_tail == NONE_IDX) a_tail = LINK_W'(s);
      memb[s] = MB_ACTIVE;
      a_cnt++;
    end else begin
      nxt[s] = i_head;
      if (i_head != NONE_IDX) prv[i_head] = LINK_W'(s);
      i_head = LINK_W'(s);
      if (i_tail == NONE_IDX) i_tail = LINK_W'(s);
      memb[s] = MB_INACTIVE;
      i_cnt++;
    end
  endfunction

  function automatic void list_unlink(input int s);
    logic [LINK_W-1:0] p, n;
    p = prv[s];
    n = nxt[s];
    if (memb[s] == MB_NONE) return;
    if (p != NONE_IDX) nxt[p] = n;
    if (n != NONE_IDX) prv[n] = p;
    if (memb[s] == MB_ACTIVE) begin
      if (a_head == s) a_head = n;
      if (a_tail == s) a_tail = p;
      if (a_cnt > 0) a_cnt--;
    end else begin
      if (i_head == s) i_head = n;
      if (i_tail == s) i_tail = p;
      if (i_cnt > 0) i_cnt--;
    end
    prv[s] = NONE_IDX;
    nxt[s] = NONE_IDX;
    memb[s] = MB_NONE;
  endfunction

  // Second chance: inactive tail first, then active tail; an active victim is demoted.
  function automatic int second_chance_pick();
    logic [LINK_W-1:0] c;
    c = i_tail;
    while (c != NONE_IDX) begin
      if (flg[c][F_LOCKED] || flg[c][F_WRITEBACK]) c = prv[c];
      else if (flg[c][F_REFERENCED]) begin
        flg[c][F_REFERENCED] = 1'b0;
        list_unlink(int'(c));
        list_push(int'(c), 1'b1);
        c = i_tail;
      end else return int'(c);
    end
    c = a_tail;
    while (c != NONE_IDX) begin
      if (flg[c][F_LOCKED] || flg[c][F_WRITEBACK]) c = prv[c];
      else if (flg[c][F_REFERENCED]) begin
        flg[c][F_REFERENCED] = 1'b0;
        list_unlink(int'(c));
        list_push(int'(c), 1'b1);
        c = a_tail;
      end else begin
        list_unlink(int'(c));
        list_push(int'(c), 1'b0);
        return int'(c);
      end
    end
    return SLOTS;
  endfunction

  function automatic outcome_t predict_request(input req_t rq, input int s,
                                               input bit hl, input bit hw);
    outcome_t o;
    bit       listed;
    int       v;
    o = '0;
    if (rq == REQ_VICTIM) begin
      v = second_chance_pick();
      if (v < SLOTS) begin
        o.found = 1'b1;
        o.vslot = IDX_W'(v);
      end
    end else if (rq == REQ_UNUSED) begin
      o.status = 1'b1;
    end else begin
      listed = memb[s] != MB_NONE;
      case (rq)
        REQ_INSERT: begin
          if (listed) o.status = 1'b1;
          else begin
            list_push(s, 1'b1);
            if (flg[s][F_DIRTY]) dirty_tot++;
          end
        end
        REQ_REMOVE: begin
          if (listed) begin
            list_unlink(s);
            if (flg[s][F_DIRTY] && dirty_tot > 0) dirty_tot--;
          end
        end
        REQ_REFERENCE: flg[s][F_REFERENCED] = 1'b1;
        REQ_DIRTY: begin
          if (!flg[s][F_DIRTY] && listed) dirty_tot++;
          flg[s][F_DIRTY] = 1'b1;
          flg[s][F_REFERENCED] = 1'b1;
        end
        REQ_CLEAN: begin
          if (flg[s][F_DIRTY] && listed && dirty_tot > 0) dirty_tot--;
          flg[s][F_DIRTY] = 1'b0;
        end
        default: begin
          flg[s][F_LOCKED] = hl;
          flg[s][F_WRITEBACK] = hw;
        end
      endcase
    end
    o.dirty = CNT_W'(dirty_tot);
    o.total = CNT_W'(a_cnt + i_cnt);
    o.throttle = (limit_reg != 0) && (dirty_tot > (limit_reg * percent_reg) / 100);
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t exp_o, act_o;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        nxt[i] = NONE_IDX;
        prv[i] = NONE_IDX;
        memb[i] = MB_NONE;
        flg[i] = '0;
      end
      a_head = NONE_IDX; a_tail = NONE_IDX; i_head = NONE_IDX; i_tail = NONE_IDX;
      a_cnt = 0; i_cnt = 0; dirty_tot = 0;
      limit_reg = 0;
      percent_reg = int'(PERCENT_RESET);
      outcome_q.delete();
      pending = 0;
      fail_count = 0;
      beats_seen = 0;
      victims_seen = 0;
    end else begin
      // A result beat never lands in the same cycle as the accept of the next request.
      if (done) begin
        act_o = '{status, victim_found, victim_slot, dirty_count, total_count, throttle};
        beats_seen++;
        if (victim_found) victims_seen++;
        if (outcome_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, actual %p", $time, act_o);
        end else begin
          exp_o = outcome_q.pop_front();
          if (act_o !== exp_o) begin
            fail_count++;
            $display("%0t: mismatch expected %p actual %p", $time, exp_o, act_o);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_PAGE_LIMIT) limit_reg = int'(cfg_data);
        else percent_reg = int'(cfg_data);
      end
      if (start && !busy)
        outcome_q.push_back(predict_request(req_t'(req_type), int'(slot), hold_locked,
                                            hold_writeback));
      pending = outcome_q.size();
    end
  end

endmodule

// ----- dv/two_list_second_chance_lru_core_tb.sv -----
// Testbench top: drives requests and configuration into the core and reports the verdict.
`timescale 1ns / 100ps
module two_list_second_chance_lru_core_tb;
  import tlsc_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [2:0]       req_type = REQ_INSERT;
  logic [IDX_W-1:0] slot = '0;
  logic             hold_locked = 1'b0;
  logic             hold_writeback = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_PAGE_LIMIT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             done, status, victim_found, throttle;
  logic [IDX_W-1:0] victim_slot;
  logic [CNT_W-1:0] dirty_count, total_count;
  int               fail_count, pending, beats_seen, victims_seen;
  int               cycles = 0;
  bit               calm = 1'b0;

  always #5 clk = ~clk;

  two_list_second_chance_lru_core DUT (.*);
  two_list_second_chance_lru_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One request beat; start stays high until busy is low at a rising edge.
  task automatic send_req(input req_t rq, input int s, input bit hl = 0,
                          input bit hw = 0);
    if (!calm) while ($urandom_range(99) < 18) @(negedge clk);
    req_type = rq;
    slot = IDX_W'(s);
    hold_locked = hl;
    hold_writeback = hw;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    drain();
    cfg_index = idx;
    cfg_data = CFG_W'(val);
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly list-building traffic over the first span slots, so victims have work to do.
  task automatic random_burst(input int count, input int span);
    int r, s;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      s = (r < 3) ? $urandom_range(63) : $urandom_range(span - 1);
      if (r < 25) send_req(REQ_INSERT, s);
      else if (r < 32) send_req(REQ_REMOVE, s);
      else if (r < 47) send_req(REQ_REFERENCE, s);
      else if (r < 57) send_req(REQ_DIRTY, s);
      else if (r < 64) send_req(REQ_CLEAN, s);
      else if (r < 72) send_req(REQ_HOLDS, s, $urandom_range(3) == 0, $urandom_range(3) == 0);
      else if (r < 97) send_req(REQ_VICTIM, $urandom_range(63));
      else send_req(REQ_UNUSED, $urandom_range(63), $urandom_range(1), $urandom_range(1));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty victim, extremes of slot, duplicate insert, holds, referenced promotion.
    send_req(REQ_VICTIM, 0);
    send_req(REQ_REMOVE, 5);
    send_req(REQ_DIRTY, 63);
    send_req(REQ_INSERT, 63);
    send_req(REQ_INSERT, 63);
    send_req(REQ_INSERT, 0);
    send_req(REQ_INSERT, 42);
    send_req(REQ_HOLDS, 0, 1, 0);
    send_req(REQ_HOLDS, 42, 0, 1);
    send_req(REQ_VICTIM, 0);
    send_req(REQ_VICTIM, 0);
    send_req(REQ_HOLDS, 0, 1, 1);
    send_req(REQ_REFERENCE, 21);
    send_req(REQ_INSERT, 21);
    send_req(REQ_VICTIM, 63);
    send_req(REQ_HOLDS, 42, 0, 0);
    send_req(REQ_CLEAN, 63);
    send_req(REQ_CLEAN, 7);
    send_req(REQ_UNUSED, 63, 1, 1);
    send_req(REQ_REMOVE, 63);
    send_req(REQ_VICTIM, 0);
    send_req(REQ_HOLDS, 0, 0, 0);

    write_reg(CFG_PAGE_LIMIT, 4);
    write_reg(CFG_DIRTY_PERCENT, 100);
    random_burst(250, 12);
    write_reg(CFG_PAGE_LIMIT, 64);
    write_reg(CFG_DIRTY_PERCENT, 0);
    calm = 1'b1;
    random_burst(250, 64);
    calm = 1'b0;
    write_reg(CFG_DIRTY_PERCENT, 10);
    random_burst(250, 24);
    write_reg(CFG_PAGE_LIMIT, 0);
    write_reg(CFG_DIRTY_PERCENT, 127);
    random_burst(200, 8);
    write_reg(CFG_PAGE_LIMIT, 127);
    write_reg(CFG_DIRTY_PERCENT, 50);
    random_burst(250, 40);

    drain();
    $display("Covered %0d result beats, %0d with a victim, over five register settings.",
             beats_seen, victims_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
